/* sv/sorted_stack_min_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Sorted stack min priority queue: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SORTED_STACK_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_STACK_MIN_PRIORITY_QUEUE_ASSERT_SVH

// checked only while out of reset
`define SSMPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SSMPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/ssmpq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted stack min priority queue: package
// Sizes, request and status codes, and the types passed between cells.
// ----------------------------------------------------------------------------
package ssmpq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast to every cell
  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic [DataWidth-1:0] value;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                 valid;
    logic                 keep;   // holds a value <= the pushed one
    logic [DataWidth-1:0] value;
  } cell_view_t;

endpackage

/* sv/ssmpq_if.sv */
// ----------------------------------------------------------------------------
// Sorted stack min priority queue: channel interfaces
// Valid/ready request and response channels.
// ----------------------------------------------------------------------------
interface ssmpq_req_if;
  import ssmpq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [DataWidth-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface ssmpq_rsp_if;
  import ssmpq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] top_value;
  logic [1:0]           status;
  logic [CntWidth-1:0]  entry_count;
  logic                 is_empty;

  modport source (output valid, top_value, status, entry_count, is_empty, input ready);
  modport sink   (input valid, top_value, status, entry_count, is_empty, output ready);
endinterface

/* sv/sorted_stack_min_priority_queue.sv */
// ----------------------------------------------------------------------------
// Sorted stack min priority queue: top level
// Bounded min queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  carries one item per request: req_type (push, pop, peek) and
//          push_value. Every accepted item gives exactly one response item.
//   rsp_o  carries top_value, status, entry_count and is_empty.
//   A push compares its value against all cells at once; each cell keeps,
//   takes the new value or takes its upper neighbor's value. A pop shifts
//   every cell up by one.
//   Latency: the response is valid the cycle after the request is accepted.
//   Throughput: one item per cycle while the response register drains; the
//   cell chain is registered and the next item sees its result directly.
//   Stall: the response register holds its item while rsp_o.ready is low;
//   req_i.ready is high whenever that register is empty or being drained.
//   Reset: all cells read as empty, count goes to zero, no response pending.
//   Empty pop/peek returns all ones with status empty; a full push is dropped
//   with status full; an undefined request kind is a no-op reporting ok.
// ----------------------------------------------------------------------------
module sorted_stack_min_priority_queue
  import ssmpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ssmpq_req_if.sink   req_i,
  ssmpq_rsp_if.source rsp_o
);

  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  // chain of cells; index 0 is the top
  cell_cmd_t  cmd;
  cell_view_t views [Depth];
  logic [CntWidth-1:0] count_q, count_d;

  // response register
  logic                 rsp_valid_q;
  logic [DataWidth-1:0] top_q,    top_d;
  logic [1:0]           status_q, status_d;

  logic accept;
  logic is_full, is_none;

  assign is_full = (count_q == CntFull);
  assign is_none = (count_q == '0);

  // the output register decouples the two sides
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign cmd.push  = accept && (req_i.req_type == REQ_PUSH) && !is_full;
  assign cmd.pop   = accept && (req_i.req_type == REQ_POP) && !is_none;
  assign cmd.value = req_i.push_value;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    cell_view_t left, right;
    if (i == 0) begin : g_head
      // nothing above the top: a non-keeping top cell loads the new value
      assign left = '{valid: 1'b1, keep: 1'b1, value: '0};
    end else begin : g_mid
      assign left = views[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right = '{valid: 1'b0, keep: 1'b0, value: '0};
    end else begin : g_body
      assign right = views[i+1];
    end
    ssmpq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .view_o (views[i])
    );
  end

  // response fields from the state before the update
  always_comb begin
    count_d  = count_q;
    top_d    = '0;
    status_d = ST_OK;
    case (req_i.req_type)
      REQ_PUSH: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (is_none) begin
          top_d    = '1;
          status_d = ST_EMPTY;
        end else begin
          top_d = views[0].value;
          if (req_i.req_type == REQ_POP) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
        // undefined kind: store untouched
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q    <= top_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.top_value   = top_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = count_q;
  assign rsp_o.is_empty    = is_none;

  // ---------------------------------------------------------------- checks
  logic [Depth-1:0] valid_vec;
  for (genvar i = 0; i < Depth; i++) begin : g_vec
    assign valid_vec[i] = views[i].valid;
  end

`include "sorted_stack_min_priority_queue_assert.svh"

  `SSMPQ_ASSERT(a_count_matches_cells, $countones(valid_vec) == 32'(count_q), "count != cells")
  `SSMPQ_ASSERT(a_count_bound, count_q <= CntFull, "count above depth")
  `SSMPQ_ASSERT(a_pop_decrements, cmd.pop |=> count_q == $past(count_q) - 1'b1, "pop count")
  `SSMPQ_ASSERT_ALWAYS(a_no_rsp_after_reset, !rst_ni |=> !rsp_valid_q || accept || !rst_ni, "rsp")

  for (genvar i = 0; i < Depth - 1; i++) begin : g_order
    `SSMPQ_ASSERT(a_sorted, views[i+1].valid |-> (views[i].valid && $signed(views[i].value) <= $signed(views[i+1].value)), "order")
  end

endmodule

/* sv/ssmpq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted stack min priority queue: storage cell
// One slot of the sorted chain; shifts down on insert, up on pop.
// ----------------------------------------------------------------------------
module ssmpq_cell
  import ssmpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  input  cell_view_t left_i,   // neighbor nearer the top
  input  cell_view_t right_i,  // neighbor farther from the top
  output cell_view_t view_o
);

  logic                 valid_q, valid_d;
  logic [DataWidth-1:0] value_q, value_d;
  logic                 keep;

  assign keep = valid_q && ($signed(value_q) <= $signed(cmd_i.value));

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.push) begin
      if (!keep) begin
        if (left_i.keep) begin
          valid_d = 1'b1;
          value_d = cmd_i.value;
        end else begin
          valid_d = left_i.valid;
          value_d = left_i.value;
        end
      end
    end else if (cmd_i.pop) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign view_o = '{valid: valid_q, keep: keep, value: value_q};

endmodule
